// ===== sv/assert_macros.svh =====
// Assertion macros for the RTL of the face normal unit.
// No dependencies; build with NO_ASSERTIONS defined to drop every check.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked on every rising edge outside reset.
`define ASSERT_CLK(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(lbl, clk, rst, prop, msg)
`define ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== sv/fnu_pkg.sv =====
// Package of the face normal unit: payload types, stage records and widths.
// No dependencies.
`default_nettype none
package fnu_pkg;

  localparam int COORD_W = 24;
  localparam int NORM_W  = 16;
  localparam int EDGE_W  = COORD_W + 1;
  localparam int PROD_W  = 2 * EDGE_W;
  localparam int CROSS_W = PROD_W + 1;
  localparam int MAG_W   = CROSS_W;
  localparam int V_W     = 31;
  localparam int K_W     = $clog2(MAG_W - V_W + 1);
  localparam int SQ_W    = 2 * V_W;
  localparam int S_W     = SQ_W + 2;
  localparam int FRAC_W  = NORM_W - 2;
  localparam int X_W     = FRAC_W + 2;
  localparam int T_SHIFT = 2 * (FRAC_W + 1);
  localparam int REM_W   = SQ_W + T_SHIFT;
  localparam int P_W     = X_W + S_W;
  localparam int TERM_W  = P_W + X_W + 2;

  typedef struct packed {
    logic signed [COORD_W-1:0] a_x;
    logic signed [COORD_W-1:0] a_y;
    logic signed [COORD_W-1:0] a_z;
    logic signed [COORD_W-1:0] b_x;
    logic signed [COORD_W-1:0] b_y;
    logic signed [COORD_W-1:0] b_z;
    logic signed [COORD_W-1:0] c_x;
    logic signed [COORD_W-1:0] c_y;
    logic signed [COORD_W-1:0] c_z;
  } face_t;

  typedef struct packed {
    logic signed [NORM_W-1:0] normal_x;
    logic signed [NORM_W-1:0] normal_y;
    logic signed [NORM_W-1:0] normal_z;
    logic                     degenerate;
  } normal_t;

  // cross product as sign and magnitude
  typedef struct packed {
    logic [2:0]            neg;
    logic [2:0][MAG_W-1:0] mag;
  } cross_t;

  // state of the digit-by-digit root x = floor(sqrt(T / S)) per component
  typedef struct packed {
    logic [2:0]            neg;
    logic                  degen;
    logic [S_W-1:0]        s;
    logic [2:0][REM_W-1:0] rem;
    logic [2:0][X_W-1:0]   x;
    logic [2:0][P_W-1:0]   p;
  } root_t;

endpackage
`default_nettype wire

// ===== sv/fnu_cross.sv =====
// Edges and exact cross product AC x AB, four stages, sign/magnitude out.
// Depends on fnu_pkg.
`default_nettype none
module fnu_cross (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fnu_pkg::face_t  in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fnu_pkg::cross_t out_data
);
  import fnu_pkg::*;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  logic signed [EDGE_W-1:0]  ab [3];
  logic signed [EDGE_W-1:0]  ac [3];
  logic signed [PROD_W-1:0]  prod [6];
  logic signed [CROSS_W-1:0] n [3];
  cross_t                    data_next;

  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  // edges
  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      ab[0] <= EDGE_W'(in_data.b_x) - EDGE_W'(in_data.a_x);
      ab[1] <= EDGE_W'(in_data.b_y) - EDGE_W'(in_data.a_y);
      ab[2] <= EDGE_W'(in_data.b_z) - EDGE_W'(in_data.a_z);
      ac[0] <= EDGE_W'(in_data.c_x) - EDGE_W'(in_data.a_x);
      ac[1] <= EDGE_W'(in_data.c_y) - EDGE_W'(in_data.a_y);
      ac[2] <= EDGE_W'(in_data.c_z) - EDGE_W'(in_data.a_z);
    end
  end

  // six partial products
  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      prod[0] <= ac[1] * ab[2];
      prod[1] <= ac[2] * ab[1];
      prod[2] <= ac[2] * ab[0];
      prod[3] <= ac[0] * ab[2];
      prod[4] <= ac[0] * ab[1];
      prod[5] <= ac[1] * ab[0];
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      for (int i = 0; i < 3; i++) begin
        n[i] <= CROSS_W'(prod[2*i]) - CROSS_W'(prod[2*i+1]);
      end
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      data_next.neg[i] = n[i][CROSS_W-1];
      data_next.mag[i] = n[i][CROSS_W-1] ? MAG_W'(-n[i]) : MAG_W'(n[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && r4) out_data <= data_next;
  end

endmodule
`default_nettype wire

// ===== sv/fnu_scale.sv =====
// Block scaling to 31 bits, squares and their sum; seeds the root pipeline.
// Depends on fnu_pkg.
`default_nettype none
module fnu_scale (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_ready,
  input  fnu_pkg::cross_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output fnu_pkg::root_t  out_data
);
  import fnu_pkg::*;

  logic v1, v2, v3;
  logic r1, r2, r3, r4;
  logic [MAG_W-1:0] m;
  logic [K_W-1:0]   k_next;
  logic [K_W-1:0]   k1;
  logic [2:0]       neg1, neg2, neg3;
  logic             degen1, degen2, degen3;
  logic [2:0][MAG_W-1:0] mag1;
  logic [V_W-1:0]   v [3];
  logic [SQ_W-1:0]  sq [3];
  root_t            data_next;

  assign r4       = !out_valid || out_ready;
  assign r3       = !v3 || r4;
  assign r2       = !v2 || r3;
  assign r1       = !v1 || r2;
  assign in_ready = r1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (r1) v1 <= in_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (r4) out_valid <= v3;
    end
  end

  // shift that brings the common magnitude below 2^31
  always_comb begin
    m      = in_data.mag[0] | in_data.mag[1] | in_data.mag[2];
    k_next = '0;
    for (int i = V_W; i < MAG_W; i++) begin
      if (m[i]) k_next = K_W'(i - V_W + 1);
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && r1) begin
      k1     <= k_next;
      degen1 <= (m == '0);
      neg1   <= in_data.neg;
      mag1   <= in_data.mag;
    end
  end

  always_ff @(posedge clk) begin
    if (v1 && r2) begin
      neg2   <= neg1;
      degen2 <= degen1;
      for (int i = 0; i < 3; i++) v[i] <= V_W'(mag1[i] >> k1);
    end
  end

  always_ff @(posedge clk) begin
    if (v2 && r3) begin
      neg3   <= neg2;
      degen3 <= degen2;
      for (int i = 0; i < 3; i++) sq[i] <= SQ_W'(v[i]) * SQ_W'(v[i]);
    end
  end

  always_comb begin
    data_next.neg   = neg3;
    data_next.degen = degen3;
    data_next.s     = S_W'(sq[0]) + S_W'(sq[1]) + S_W'(sq[2]);
    for (int i = 0; i < 3; i++) begin
      data_next.rem[i] = REM_W'(sq[i]) << T_SHIFT;
      data_next.x[i]   = '0;
      data_next.p[i]   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (v3 && r4) out_data <= data_next;
  end

endmodule
`default_nettype wire

// ===== sv/fnu_root_step.sv =====
// One digit of x = floor(sqrt(T / S)) for all three components.
// Depends on fnu_pkg; keeps P = x * S so each digit needs only shifts and adds.
`default_nettype none
module fnu_root_step #(
  parameter int STEP = 0
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  fnu_pkg::root_t in_data,
  output logic           out_valid,
  input  logic           out_ready,
  output fnu_pkg::root_t out_data
);
  import fnu_pkg::*;

  logic [TERM_W-1:0] term [3];
  root_t             data_next;

  // (x + b)^2 S - x^2 S = (x * S) << (STEP+1) + S << (2*STEP), b = 2^STEP
  always_comb begin
    data_next = in_data;
    for (int i = 0; i < 3; i++) begin
      term[i] = (TERM_W'(in_data.p[i]) << (STEP + 1)) + (TERM_W'(in_data.s) << (2 * STEP));
      if (TERM_W'(in_data.rem[i]) >= term[i]) begin
        data_next.rem[i] = in_data.rem[i] - REM_W'(term[i]);
        data_next.x[i]   = in_data.x[i] | (X_W'(1) << STEP);
        data_next.p[i]   = in_data.p[i] + (P_W'(in_data.s) << STEP);
      end
    end
  end

  assign in_ready = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_ready) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) out_data <= data_next;
  end

endmodule
`default_nettype wire

// ===== sv/face_normal_unit.sv =====
// Face normal unit: unit normal of triangle ABC as (AC x AB) / |AC x AB| in Q1.14.
// Stages: cross product, scaling, 16 root digits and an output register.
// Throughput one face per cycle while normal_stall is low; each of the 16 root stages resolves one digit.
// Bubbles are squeezed out under stall; every stage holds its transfer in place.
// Reset (rst, synchronous) clears the valid bits only; payload registers keep data.
// Depends on fnu_pkg, fnu_cross, fnu_scale, fnu_root_step and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module face_normal_unit (
  input  logic             clk,
  input  logic             rst,
  input  logic             face_valid,
  output logic             face_stall,
  input  fnu_pkg::face_t   face,
  output logic             normal_valid,
  input  logic             normal_stall,
  output fnu_pkg::normal_t normal
);
  import fnu_pkg::*;

  localparam logic signed [NORM_W-1:0] UNIT = NORM_W'(1) << FRAC_W;

  logic   face_ready;
  logic   cross_valid, cross_ready;
  cross_t cross_data;

  // root pipeline chain: index 0 is the seed, index X_W the finished root
  logic  chain_valid [X_W+1];
  logic  chain_ready [X_W+1];
  root_t chain_data  [X_W+1];

  logic    out_ready;
  normal_t normal_next;
  logic [X_W-1:0]  q [3];
  logic [NORM_W-1:0] comp [3];
  root_t   fin;

  assign face_stall = !face_ready;

  fnu_cross u_cross (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (face_valid),
    .in_ready  (face_ready),
    .in_data   (face),
    .out_valid (cross_valid),
    .out_ready (cross_ready),
    .out_data  (cross_data)
  );

  fnu_scale u_scale (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (cross_valid),
    .in_ready  (cross_ready),
    .in_data   (cross_data),
    .out_valid (chain_valid[0]),
    .out_ready (chain_ready[0]),
    .out_data  (chain_data[0])
  );

  // digits from the most significant down
  for (genvar g = 0; g < X_W; g++) begin : g_root
    fnu_root_step #(
      .STEP (X_W - 1 - g)
    ) u_step (
      .clk       (clk),
      .rst       (rst),
      .in_valid  (chain_valid[g]),
      .in_ready  (chain_ready[g]),
      .in_data   (chain_data[g]),
      .out_valid (chain_valid[g+1]),
      .out_ready (chain_ready[g+1]),
      .out_data  (chain_data[g+1])
    );
  end

  assign fin                = chain_data[X_W];
  assign out_ready          = !normal_valid || !normal_stall;
  assign chain_ready[X_W]   = out_ready;

  // largest odd 2q-1 not above x gives q = (x + 1) / 2; at most 2^14
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      q[i]    = X_W'(({1'b0, fin.x[i]} + (X_W+1)'(1)) >> 1);
      comp[i] = fin.neg[i] ? NORM_W'(-q[i]) : NORM_W'(q[i]);
      if (fin.degen) comp[i] = '0;
    end
    normal_next.normal_x   = comp[0];
    normal_next.normal_y   = comp[1];
    normal_next.normal_z   = comp[2];
    normal_next.degenerate = fin.degen;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      normal_valid <= 1'b0;
    end else if (out_ready) begin
      normal_valid <= chain_valid[X_W];
    end
  end

  always_ff @(posedge clk) begin
    if (chain_valid[X_W] && out_ready) normal <= normal_next;
  end

  `ASSERT_CLK(a_degen_zero, clk, rst, normal_valid && normal.degenerate |-> normal.normal_x == '0 && normal.normal_y == '0 && normal.normal_z == '0, "degenerate face with non-zero normal")
  `ASSERT_CLK(a_unit_range, clk, rst, normal_valid |-> normal.normal_x <= UNIT && normal.normal_x >= -UNIT && normal.normal_y <= UNIT && normal.normal_y >= -UNIT && normal.normal_z <= UNIT && normal.normal_z >= -UNIT, "normal component beyond unit")
  `ASSERT_CLK(a_empty_accepts, clk, rst, !normal_valid |-> !face_stall, "input stalled with empty output")
  `ASSERT_ALWAYS(a_reset_clears, clk, rst |=> !normal_valid, "result valid straight after reset")

endmodule
`default_nettype wire
